>>> rtl/smtc_pkg.sv
// Shared types, codes and defaults of the semi-Markov transition counter.
package smtc_pkg;

   localparam int MAX_STATES_DEF = 16;
   localparam int MAX_LEN_DEF    = 64;
   localparam int COUNT_BITS_DEF = 32;

   localparam logic [4:0] NUM_STATES_RESET  = 5'd16;
   localparam logic [6:0] MAX_SOJOURN_RESET = 7'd64;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef enum logic [1:0] {
      TBL_START,
      TBL_TRANS,
      TBL_BEGIN,
      TBL_END
   } table_sel_type;

   typedef enum logic {
      CSR_NUM_STATES,
      CSR_MAX_SOJOURN
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_DELIVER
   } ctrl_state_type;

   typedef struct packed {
      logic          cmd;
      logic [3:0]    visit_state;
      logic [6:0]    sojourn_len;
      logic          last_visit;
      table_sel_type table_sel;
      logic [3:0]    from_state;
      logic [3:0]    to_state;
      logic [5:0]    length_index;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [31:0] count_value;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic lookup;
      logic update;
      logic deliver;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } dp_status_type;

endpackage

>>> rtl/semi_markov_transition_counter_unit.sv
// Top level of the semi-Markov transition counter: controller and datapath.
//
//   channel   ports                                   direction
//   request   req_valid, req_ready, req_payload       in
//   response  rsp_valid, rsp_ready, rsp_payload       out
//   config    csr_we, csr_index, csr_wdata            in
//
// Each request passes from acceptance to its response through the read-modify-write
// of the count memories: capture, memory read, write-back, output load.
// A new request is taken at the earliest in the cycle after the previous response is
// loaded, so a request is not taken before the unit is through with the last one.
// After reset a clearing pass over all MaxStates * MaxStates * MaxLen pair addresses (16384
// by default) zeroes the memories; req_ready stays low, configuration writes are taken.
// A response waits in the output register while the next request is accepted.
module semi_markov_transition_counter_unit import smtc_pkg::*; #(
   parameter int MaxStates = MAX_STATES_DEF,
   parameter int MaxLen    = MAX_LEN_DEF,
   parameter int CountBits = COUNT_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_payload,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_payload,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [6:0]    csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   smtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   smtc_datapath #(
      .MaxStates (MaxStates),
      .MaxLen    (MaxLen),
      .CountBits (CountBits)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> rtl/smtc_ctrl.sv
// Controller state machine: clearing pass, request sequencing and the response valid flag.
module smtc_ctrl import smtc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.deliver = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      rsp_valid_in = cmd.deliver || (rsp_valid_ff && !rsp_ready);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/smtc_datapath.sv
// Datapath: limits, range checks, sequence state, the four count memories and the result registers.
module smtc_datapath import smtc_pkg::*; #(
   parameter int MaxStates = MAX_STATES_DEF,
   parameter int MaxLen    = MAX_LEN_DEF,
   parameter int CountBits = COUNT_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  req_type       req_payload,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [6:0]    csr_wdata,
   output rsp_type       rsp_payload
);

   localparam int PairDepth = MaxStates * MaxStates * MaxLen;
   localparam int EndDepth  = MaxStates * MaxLen;
   localparam int PairW     = $clog2(PairDepth);
   localparam int EndW      = $clog2(EndDepth);
   localparam int StartW    = $clog2(MaxStates);

   logic [CountBits-1:0] start_mem [MaxStates];
   logic [CountBits-1:0] trans_mem [PairDepth];
   logic [CountBits-1:0] begin_mem [PairDepth];
   logic [CountBits-1:0] end_mem   [EndDepth];

   logic [CountBits-1:0] start_rd_ff, trans_rd_ff, begin_rd_ff, end_rd_ff;

   logic [4:0]       num_states_ff, num_states_in;
   logic [6:0]       max_sojourn_ff, max_sojourn_in;
   logic             in_seq_ff, in_seq_in;
   logic             first_pend_ff, first_pend_in;
   logic [3:0]       prev_state_ff, prev_state_in;
   logic [6:0]       prev_len_ff, prev_len_in;
   logic [PairW-1:0] clr_ff, clr_in;
   req_type          req_ff;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff;

   logic             st_ok, len_ok, from_ok, to_ok, li_ok;
   logic             push_ok, read_ok, ok, is_push, upd;
   logic             start_we, trans_we, begin_we, end_we;
   logic [6:0]       prev_len_idx, len_idx;
   logic [3:0]       start_sel;
   logic [StartW-1:0] start_addr;
   logic [PairW-1:0] pair_addr_sel;
   logic [EndW-1:0]  end_addr_sel;
   logic [CountBits-1:0] read_value;

   function automatic logic [PairW-1:0] pair_addr(logic [3:0] f, logic [3:0] t, logic [6:0] l);
      pair_addr = PairW'((PairW'(f) * PairW'(MaxStates) + PairW'(t)) * PairW'(MaxLen)
                         + PairW'(l));
   endfunction

   function automatic logic [EndW-1:0] end_addr(logic [3:0] s, logic [6:0] l);
      end_addr = EndW'(EndW'(s) * EndW'(MaxLen) + EndW'(l));
   endfunction

   function automatic logic [CountBits-1:0] sat_inc(logic [CountBits-1:0] c);
      sat_inc = (c == '1) ? c : c + 1'b1;
   endfunction

   always_comb begin
      num_states_in  = num_states_ff;
      max_sojourn_in = max_sojourn_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_NUM_STATES:  num_states_in  = csr_wdata[4:0];
            CSR_MAX_SOJOURN: max_sojourn_in = csr_wdata;
            default:         num_states_in  = num_states_ff;
         endcase
      end
   end

   always_comb begin
      st_ok   = ({1'b0, req_ff.visit_state} < num_states_ff) &&
                (int'(req_ff.visit_state) < MaxStates);
      len_ok  = (req_ff.sojourn_len != 7'd0) && (req_ff.sojourn_len <= max_sojourn_ff) &&
                (int'(req_ff.sojourn_len) <= MaxLen);
      from_ok = ({1'b0, req_ff.from_state} < num_states_ff) &&
                (int'(req_ff.from_state) < MaxStates);
      to_ok   = ({1'b0, req_ff.to_state} < num_states_ff) &&
                (int'(req_ff.to_state) < MaxStates);
      li_ok   = ({1'b0, req_ff.length_index} < max_sojourn_ff) &&
                (int'(req_ff.length_index) < MaxLen);
      push_ok = st_ok && len_ok;
      case (req_ff.table_sel)
         TBL_START: read_ok = from_ok;
         TBL_TRANS: read_ok = from_ok && to_ok && li_ok;
         TBL_BEGIN: read_ok = from_ok && to_ok && li_ok;
         TBL_END:   read_ok = from_ok && li_ok;
         default:   read_ok = 1'b0;
      endcase
      is_push = (req_ff.cmd == CMD_PUSH);
      ok      = is_push ? push_ok : read_ok;
      upd     = cmd.update && is_push && push_ok;
   end

   always_comb begin
      prev_len_idx  = prev_len_ff - 7'd1;
      len_idx       = is_push ? req_ff.sojourn_len - 7'd1 : {1'b0, req_ff.length_index};
      start_sel     = is_push ? req_ff.visit_state : req_ff.from_state;
      start_addr    = StartW'(start_sel);
      pair_addr_sel = is_push ? pair_addr(prev_state_ff, req_ff.visit_state, prev_len_idx)
                              : pair_addr(req_ff.from_state, req_ff.to_state, len_idx);
      end_addr_sel  = end_addr(start_sel, len_idx);
   end

   assign start_we = upd && !in_seq_ff;
   assign trans_we = upd && in_seq_ff;
   assign begin_we = trans_we && first_pend_ff;
   assign end_we   = upd && req_ff.last_visit;

   always_comb begin
      in_seq_in     = in_seq_ff;
      first_pend_in = first_pend_ff;
      prev_state_in = prev_state_ff;
      prev_len_in   = prev_len_ff;
      if (upd) begin
         if (!in_seq_ff) begin
            first_pend_in = 1'b1;
         end else if (first_pend_ff) begin
            first_pend_in = 1'b0;
         end
         if (req_ff.last_visit) begin
            in_seq_in     = 1'b0;
            first_pend_in = 1'b0;
         end else begin
            in_seq_in     = 1'b1;
            prev_state_in = req_ff.visit_state;
            prev_len_in   = req_ff.sojourn_len;
         end
      end
   end

   always_comb begin
      case (req_ff.table_sel)
         TBL_START: read_value = start_rd_ff;
         TBL_TRANS: read_value = trans_rd_ff;
         TBL_BEGIN: read_value = begin_rd_ff;
         TBL_END:   read_value = end_rd_ff;
         default:   read_value = '0;
      endcase
      res_in.status      = !ok;
      res_in.count_value = (!is_push && ok) ? 32'(read_value) : 32'd0;
   end

   assign clr_in            = cmd.clear ? clr_ff + 1'b1 : clr_ff;
   assign status.clear_last = (clr_ff == PairW'(PairDepth - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         num_states_ff  <= NUM_STATES_RESET;
         max_sojourn_ff <= MAX_SOJOURN_RESET;
         in_seq_ff      <= 1'b0;
         first_pend_ff  <= 1'b0;
         prev_state_ff  <= '0;
         prev_len_ff    <= '0;
         clr_ff         <= '0;
      end else begin
         num_states_ff  <= num_states_in;
         max_sojourn_ff <= max_sojourn_in;
         in_seq_ff      <= in_seq_in;
         first_pend_ff  <= first_pend_in;
         prev_state_ff  <= prev_state_in;
         prev_len_ff    <= prev_len_in;
         clr_ff         <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
      end
      if (cmd.update) begin
         res_ff <= res_in;
      end
      if (cmd.deliver) begin
         rsp_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         if (clr_ff < PairW'(MaxStates)) begin
            start_mem[clr_ff[StartW-1:0]] <= '0;
         end
      end else if (start_we) begin
         start_mem[start_addr] <= sat_inc(start_rd_ff);
      end
      if (cmd.lookup) begin
         start_rd_ff <= start_mem[start_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         trans_mem[clr_ff] <= '0;
      end else if (trans_we) begin
         trans_mem[pair_addr_sel] <= sat_inc(trans_rd_ff);
      end
      if (cmd.lookup) begin
         trans_rd_ff <= trans_mem[pair_addr_sel];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         begin_mem[clr_ff] <= '0;
      end else if (begin_we) begin
         begin_mem[pair_addr_sel] <= sat_inc(begin_rd_ff);
      end
      if (cmd.lookup) begin
         begin_rd_ff <= begin_mem[pair_addr_sel];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         if (clr_ff < PairW'(EndDepth)) begin
            end_mem[clr_ff[EndW-1:0]] <= '0;
         end
      end else if (end_we) begin
         end_mem[end_addr_sel] <= sat_inc(end_rd_ff);
      end
      if (cmd.lookup) begin
         end_rd_ff <= end_mem[end_addr_sel];
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/smtc_checker.sv
// Port-level checker of the semi-Markov transition counter and its binding.
module smtc_checker import smtc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ready or response valid after reset");

   a_one_at_a_time : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in work");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   a_reject_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status) |-> (rsp_payload.count_value == 32'd0))
      else $error("rejected request returned a count");

endmodule

bind semi_markov_transition_counter_unit smtc_checker u_smtc_checker (.*);
